// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Property that must never hold.
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  `ASSERT_ALWAYS(lbl, clk, rstn, !(prop), msg)

`endif

// ===== hw/rtl/pnat_pkg.sv =====
// Package for the port number allocator table: sizes, codes and types.
package pnat_pkg;

  localparam int MAX_SLOTS  = 1024;
  localparam int KEY_BITS   = 32;
  localparam int OWNER_BITS = 8;
  localparam int IDX_W      = $clog2(MAX_SLOTS);
  localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
  localparam int PORT_W     = 16;
  localparam int FREE_W     = 11;

  typedef enum logic [2:0] {
    OP_REGISTER   = 3'd0,
    OP_UNREGISTER = 3'd1,
    OP_LOOKUP     = 3'd2,
    OP_REREGISTER = 3'd3,
    OP_RELEASE    = 3'd4,
    OP_CLEANUP    = 3'd5,
    OP_PRELOAD    = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ALREADY   = 3'd1,
    ST_NO_FREE   = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_NO_RECOV  = 3'd4,
    ST_OUT_RANGE = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_DECIDE = 4'b1000
  } state_e;

  localparam int REG_PORT_BASE = 0;
  localparam int REG_PORTS_USE = 1;

  typedef struct packed {
    logic                  used;
    logic [OWNER_BITS-1:0] owner;
    logic [KEY_BITS-1:0]   key;
  } entry_t;

  typedef struct packed {
    logic                  hit;
    logic [IDX_W-1:0]      hit_idx;
    logic [OWNER_BITS-1:0] hit_own;
    logic                  free_hit;
    logic [IDX_W-1:0]      free_idx;
    logic                  tgt_used;
    logic [OWNER_BITS-1:0] tgt_own;
  } scan_res_t;

endpackage

// ===== hw/rtl/pnat_if.sv =====
// Valid/ready channel interfaces for requests and responses.
interface pnat_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] service_key;
  logic [15:0] port_number;
  logic [7:0]  owner_id;
  modport source (output valid, operation, service_key, port_number, owner_id, input ready);
  modport sink (input valid, operation, service_key, port_number, owner_id, output ready);
endinterface

interface pnat_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] port_result;
  logic [10:0] free_slots;
  modport source (output valid, status, port_result, free_slots, input ready);
  modport sink (input valid, status, port_result, free_slots, output ready);
endinterface

// ===== hw/rtl/pnat_scan.sv =====
// Scan collector: first key hit, first empty slot and target slot contents.
module pnat_scan
  import pnat_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                rd_vld_i,
  input  logic [IDX_W-1:0]    rd_idx_i,
  input  entry_t              rd_entry_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [IDX_W-1:0]    tgt_idx_i,
  output scan_res_t           res_o
);

  scan_res_t res_q, res_d;

  always_comb begin
    res_d = res_q;
    if (start_i) begin
      res_d.hit      = 1'b0;
      res_d.free_hit = 1'b0;
      res_d.tgt_used = 1'b0;
      res_d.tgt_own  = '0;
    end else if (rd_vld_i) begin
      if (!res_q.hit && rd_entry_i.used && rd_entry_i.key == key_i) begin
        res_d.hit     = 1'b1;
        res_d.hit_idx = rd_idx_i;
        res_d.hit_own = rd_entry_i.owner;
      end
      if (!res_q.free_hit && !rd_entry_i.used) begin
        res_d.free_hit = 1'b1;
        res_d.free_idx = rd_idx_i;
      end
      if (rd_idx_i == tgt_idx_i) begin
        res_d.tgt_used = rd_entry_i.used;
        res_d.tgt_own  = rd_entry_i.owner;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== hw/rtl/port_number_allocator_table_core.sv =====
// Top level of the port number allocator table.
//
//  channel | dir | handshake      | payload
//  req_i   | in  | valid/ready    | operation, service_key, port_number, owner_id
//  rsp_o   | out | valid/ready    | status, port_result, free_slots
//  apb     | in  | psel/penable   | port_base (0x0), ports_in_use (0x4)
//
// Every item scans all active slots, one memory read a cycle through the single
// read port of the slot memory. Reset and every config write start a clearing
// pass over all MAX_SLOTS entries of the memory; no item is taken meanwhile. A
// stalled response holds the finishing item; the next item can be taken while a
// response waits.
`include "assert_macros.svh"
module port_number_allocator_table_core
  import pnat_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  pnat_req_if.sink      req_i,
  pnat_rsp_if.source    rsp_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  state_e state_q, state_d;

  logic [15:0]         base_q;
  logic [10:0]         piu_q;
  logic [CNT_W-1:0]    fc_q, fc_d;
  logic [IDX_W-1:0]    clr_cnt_q;
  logic [CNT_W-1:0]    rd_cnt_q;
  logic                rd_vld_q;
  logic [IDX_W-1:0]    rd_idx_q;
  entry_t              rdata_q;

  op_e                 op_q;
  logic [2:0]          op_raw_q;
  logic [KEY_BITS-1:0] key_q;
  logic [15:0]         req_q;
  logic [OWNER_BITS-1:0] own_q;

  logic                out_vld_q;
  status_e             out_st_q;
  logic [15:0]         out_port_q;
  logic [10:0]         out_free_q;

  entry_t              mem_q [MAX_SLOTS];
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  entry_t              mem_wdata;

  logic                cfg_we;
  logic                accept;
  logic                rd_en;
  logic                proceed;
  logic [CNT_W-1:0]    n_act;
  logic [16:0]         lim;
  logic [15:0]         tgt_diff;
  logic                oor;
  logic                rel_we;
  scan_res_t           sres;

  // decision outputs
  status_e             d_st;
  logic [15:0]         d_port;
  logic                d_we;
  logic                d_used;
  logic [OWNER_BITS-1:0] d_own;
  logic [IDX_W-1:0]    d_addr;
  logic [CNT_W-1:0]    d_fc;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = paddr[2] ? {21'b0, piu_q} : {16'b0, base_q};

  // active slots: min(ports_in_use, MAX_SLOTS, 65536 - base)
  always_comb begin
    logic [16:0] m;
    lim = 17'h10000 - {1'b0, base_q};
    m   = {6'b0, piu_q};
    if (m > 17'(MAX_SLOTS)) m = 17'(MAX_SLOTS);
    if (m > lim) m = lim;
    n_act = m[CNT_W-1:0];
  end

  assign tgt_diff = req_q - base_q;
  assign oor = (req_q < base_q) || ({1'b0, tgt_diff} >= 17'(n_act));

  assign accept      = (state_q == S_IDLE) && req_i.valid;
  assign req_i.ready = (state_q == S_IDLE);
  assign rd_en       = (state_q == S_SCAN) && (rd_cnt_q < n_act);
  assign proceed     = (state_q == S_DECIDE) && (!out_vld_q || rsp_o.ready);

  // slots freed on the fly by release owner and cleanup tick
  always_comb begin
    rel_we = 1'b0;
    if (rd_vld_q && rdata_q.used) begin
      if (op_raw_q == OP_RELEASE && own_q != '0 && rdata_q.owner == own_q) rel_we = 1'b1;
      if (op_raw_q == OP_CLEANUP && rdata_q.owner == '0) rel_we = 1'b1;
    end
  end

  pnat_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .rd_vld_i   (rd_vld_q),
    .rd_idx_i   (rd_idx_q),
    .rd_entry_i (rdata_q),
    .key_i      (key_q),
    .tgt_idx_i  (tgt_diff[IDX_W-1:0]),
    .res_o      (sres)
  );

  always_comb begin
    d_st   = ST_OK;
    d_port = '0;
    d_we   = 1'b0;
    d_used = 1'b1;
    d_own  = own_q;
    d_addr = sres.hit_idx;
    d_fc   = fc_q;
    case (op_q)
      OP_REGISTER: begin
        if (sres.hit && sres.hit_own != '0) begin
          d_st   = ST_ALREADY;
          d_port = base_q + 16'(sres.hit_idx);
        end else if (fc_q == '0) begin
          d_st = ST_NO_FREE;
        end else if (sres.hit) begin
          d_we   = 1'b1;
          d_port = base_q + 16'(sres.hit_idx);
        end else if (sres.free_hit) begin
          d_we   = 1'b1;
          d_addr = sres.free_idx;
          d_fc   = fc_q - 1'b1;
          d_port = base_q + 16'(sres.free_idx);
        end else begin
          d_st = ST_NO_FREE;
        end
      end
      OP_UNREGISTER: begin
        if (sres.hit) begin
          d_we   = 1'b1;
          d_used = 1'b0;
          d_own  = '0;
          d_fc   = fc_q + 1'b1;
          d_port = base_q + 16'(sres.hit_idx);
        end
      end
      OP_LOOKUP: begin
        if (sres.hit && sres.hit_own != '0) d_port = base_q + 16'(sres.hit_idx);
        else d_st = ST_UNKNOWN;
      end
      OP_REREGISTER: begin
        if (sres.hit) begin
          d_port = base_q + 16'(sres.hit_idx);
          if (sres.hit_own == '0 && d_port == req_q) d_we = 1'b1;
          else d_st = ST_NO_RECOV;
        end else if (oor) begin
          d_st = ST_OUT_RANGE;
        end else if (sres.tgt_own == '0) begin
          d_we   = 1'b1;
          d_addr = tgt_diff[IDX_W-1:0];
          d_port = req_q;
          if (!sres.tgt_used && fc_q != '0) d_fc = fc_q - 1'b1;
        end else begin
          d_st = ST_NO_RECOV;
        end
      end
      OP_RELEASE, OP_CLEANUP: begin
      end
      OP_PRELOAD: begin
        if (oor) begin
          d_st = ST_OUT_RANGE;
        end else begin
          d_we   = 1'b1;
          d_own  = '0;
          d_addr = tgt_diff[IDX_W-1:0];
          d_port = req_q;
          if (!sres.tgt_used && fc_q != '0) d_fc = fc_q - 1'b1;
        end
      end
      default: d_st = ST_UNKNOWN;
    endcase
  end

  // memory write port: clearing pass, scan frees, final update
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_q;
    mem_wdata = '0;
    if (state_q == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (rel_we) begin
      mem_we    = 1'b1;
      mem_waddr = rd_idx_q;
    end else if (proceed && d_we) begin
      mem_we    = 1'b1;
      mem_waddr = d_addr;
      mem_wdata = '{used: d_used, owner: d_own, key: d_used ? key_q : '0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (rd_en) rdata_q <= mem_q[rd_cnt_q[IDX_W-1:0]];
  end

  always_comb begin
    state_d = state_q;
    fc_d    = fc_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_cnt_q == IDX_W'(MAX_SLOTS - 1)) begin
          state_d = S_IDLE;
          fc_d    = n_act;
        end
      end
      S_IDLE:   if (req_i.valid) state_d = S_SCAN;
      S_SCAN: begin
        if (rel_we) fc_d = fc_q + 1'b1;
        if (!rd_en && !rd_vld_q) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (proceed) begin
          state_d = S_IDLE;
          fc_d    = d_fc;
        end
      end
      default: state_d = S_CLEAR;
    endcase
    if (cfg_we) state_d = S_CLEAR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      base_q    <= 16'd1024;
      piu_q     <= 11'd1024;
      fc_q      <= '0;
      clr_cnt_q <= '0;
      rd_cnt_q  <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fc_q     <= fc_d;
      rd_vld_q <= rd_en;
      if (state_q == S_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cfg_we) begin
        clr_cnt_q <= '0;
        if (paddr[2] == 1'(REG_PORTS_USE)) piu_q <= pwdata[10:0];
        else base_q <= pwdata[15:0];
      end
      if (accept) rd_cnt_q <= '0;
      else if (rd_en) rd_cnt_q <= rd_cnt_q + 1'b1;
      if (proceed) out_vld_q <= 1'b1;
      else if (rsp_o.ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_idx_q <= rd_cnt_q[IDX_W-1:0];
    if (accept) begin
      op_q     <= op_e'(req_i.operation);
      op_raw_q <= req_i.operation;
      key_q    <= req_i.service_key[KEY_BITS-1:0];
      req_q    <= req_i.port_number;
      own_q    <= req_i.owner_id[OWNER_BITS-1:0];
    end
    if (proceed) begin
      out_st_q   <= d_st;
      out_port_q <= d_port;
      out_free_q <= FREE_W'(d_fc);
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.status      = out_st_q;
  assign rsp_o.port_result = out_port_q;
  assign rsp_o.free_slots  = out_free_q;

  `ASSERT_ALWAYS(a_fc_bound, clk_i, rst_ni, (state_q == S_IDLE) |-> (fc_q <= n_act), "free count above active slots")
  `ASSERT_NEVER(a_rw_clash, clk_i, rst_ni, rel_we && rd_en && (rd_idx_q == rd_cnt_q[IDX_W-1:0]), "scan write hits read address")
  `ASSERT_ALWAYS(a_rsp_src, clk_i, rst_ni, $rose(out_vld_q) |-> $past(state_q == S_DECIDE), "response without decision")

endmodule

// ===== dv/pnat_checker.sv =====
// Checker for the port number allocator table: watches channels, predicts results, compares.
`timescale 1ns / 1ps
module pnat_checker
  import pnat_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  pnat_req_if         req,
  pnat_rsp_if         rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_cnt_o,
  output int          pending_o
);

  typedef struct {
    status_e     st;
    logic [15:0] port;
    logic [10:0] free;
  } rsp_exp_t;

  rsp_exp_t rsp_exp_q[$];

  logic [15:0]           cfg_base;
  logic [10:0]           cfg_ports;
  logic                  tbl_used [MAX_SLOTS];
  logic [KEY_BITS-1:0]   tbl_key  [MAX_SLOTS];
  logic [OWNER_BITS-1:0] tbl_owner[MAX_SLOTS];
  int                    free_cnt;
  int                    fail_cnt;

  function automatic int slots_active();
    int n;
    n = cfg_ports;
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    if (n > 65536 - int'(cfg_base)) n = 65536 - int'(cfg_base);
    return n;
  endfunction

  task automatic wipe_table();
    for (int i = 0; i < MAX_SLOTS; i++) begin
      tbl_used[i]  = 1'b0;
      tbl_key[i]   = '0;
      tbl_owner[i] = '0;
    end
    free_cnt = slots_active();
  endtask

  function automatic int key_slot(logic [KEY_BITS-1:0] k);
    int n;
    n = slots_active();
    for (int i = 0; i < n; i++)
      if (tbl_used[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  task automatic drop_slot(int i);
    tbl_used[i]  = 1'b0;
    tbl_key[i]   = '0;
    tbl_owner[i] = '0;
    free_cnt++;
  endtask

  task automatic take_slot(int i, logic [KEY_BITS-1:0] k, logic [OWNER_BITS-1:0] o);
    // count drops only when an empty slot gets filled
    if (!tbl_used[i] && free_cnt > 0) free_cnt--;
    tbl_used[i]  = 1'b1;
    tbl_key[i]   = k;
    tbl_owner[i] = o;
  endtask

  task automatic predict_alloc(logic [2:0] op, logic [31:0] k, logic [15:0] req_port,
                               logic [7:0] own, output rsp_exp_t e);
    int n, f, i, base, rp;
    n = slots_active();
    base = cfg_base;
    rp = req_port;
    e.st = ST_OK;
    e.port = '0;
    case (op)
      OP_REGISTER: begin
        f = key_slot(k);
        if (f >= 0 && tbl_owner[f] != 0) begin
          e.st = ST_ALREADY;
          e.port = 16'(base + f);
        end else if (free_cnt == 0) begin
          e.st = ST_NO_FREE;
        end else if (f >= 0) begin
          tbl_owner[f] = own;
          e.port = 16'(base + f);
        end else begin
          i = 0;
          while (i < n && tbl_used[i]) i++;
          if (i < n) begin
            take_slot(i, k, own);
            e.port = 16'(base + i);
          end else begin
            e.st = ST_NO_FREE;
          end
        end
      end
      OP_UNREGISTER: begin
        if (free_cnt != n) begin
          f = key_slot(k);
          if (f >= 0) begin
            e.port = 16'(base + f);
            drop_slot(f);
          end
        end
      end
      OP_LOOKUP: begin
        f = key_slot(k);
        if (f >= 0 && tbl_owner[f] != 0) e.port = 16'(base + f);
        else e.st = ST_UNKNOWN;
      end
      OP_REREGISTER: begin
        f = key_slot(k);
        if (f >= 0) begin
          e.port = 16'(base + f);
          if (tbl_owner[f] == 0 && base + f == rp) tbl_owner[f] = own;
          else e.st = ST_NO_RECOV;
        end else if (rp < base || rp - base >= n) begin
          e.st = ST_OUT_RANGE;
        end else begin
          i = rp - base;
          if (tbl_owner[i] == 0) begin
            take_slot(i, k, own);
            e.port = req_port;
          end else begin
            e.st = ST_NO_RECOV;
          end
        end
      end
      OP_RELEASE: begin
        if (own != 0)
          for (i = 0; i < n; i++)
            if (tbl_used[i] && tbl_owner[i] == own) drop_slot(i);
      end
      OP_CLEANUP: begin
        for (i = 0; i < n; i++)
          if (tbl_used[i] && tbl_owner[i] == 0) drop_slot(i);
      end
      OP_PRELOAD: begin
        if (rp < base || rp - base >= n) begin
          e.st = ST_OUT_RANGE;
        end else begin
          take_slot(rp - base, k, '0);
          e.port = req_port;
        end
      end
      default: e.st = ST_UNKNOWN;
    endcase
    e.free = 11'(free_cnt);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_exp_t e;
    if (!rst_ni) begin
      cfg_base  = 16'd1024;
      cfg_ports = 11'd1024;
      wipe_table();
      rsp_exp_q.delete();
    end else begin
      // responses first: a response at this edge belongs to an older item
      if (rsp.valid && rsp.ready) begin
        if (rsp_exp_q.size() == 0) begin
          $display("%0t response with no item waiting", $realtime);
          fail_cnt++;
        end else begin
          e = rsp_exp_q.pop_front();
          if (rsp.status !== e.st) report_mismatch("status", rsp.status, e.st);
          if (rsp.port_result !== e.port) report_mismatch("port", rsp.port_result, e.port);
          if (rsp.free_slots !== e.free) report_mismatch("free", rsp.free_slots, e.free);
        end
      end
      if (req.valid && req.ready) begin
        predict_alloc(req.operation, req.service_key, req.port_number, req.owner_id, e);
        rsp_exp_q.push_back(e);
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == 1'b0) begin
          cfg_base = pwdata[15:0];
          wipe_table();
        end else begin
          cfg_ports = pwdata[10:0];
          wipe_table();
        end
      end
    end
    pending_o = rsp_exp_q.size();
  end

  initial begin
    fail_cnt  = 0;
    pending_o = 0;
  end
  assign fail_cnt_o = fail_cnt;

endmodule

// ===== dv/testbench.sv =====
// Top of the port number allocator table testbench: stimulus, idling and verdict.
`timescale 1ns / 1ps
module testbench;
  import pnat_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_cnt;
  int          pending;

  pnat_req_if req ();
  pnat_rsp_if rsp ();

  port_number_allocator_table_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rsp_o   (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pnat_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req),
    .rsp        (rsp),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  int          tx_idle, rx_idle;
  int          sent_cnt;
  bit          rx_held;
  int          hold_left;
  logic [15:0] cur_base;
  int          cur_slots;
  logic [31:0] key_pool[6] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'hA5A5_0001,
                               32'h0000_0042, 32'h8000_0000};

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #80_000_000;
    $display("Some tests failed");
    $finish;
  end

  // receiver: random idling plus one long hold-off to back the block up
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
      rx_held   <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp.ready <= 1'b0;
    end else if (!rx_held && sent_cnt >= 250) begin
      rx_held   <= 1'b1;
      hold_left <= 400;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  task automatic set_idling();
    if (sent_cnt < 195) begin
      tx_idle = 35; rx_idle = 46;
    end else if (sent_cnt < 390) begin
      tx_idle = 46; rx_idle = 35;
    end else begin
      tx_idle = 0; rx_idle = 0;
    end
  endtask

  task automatic send_item(logic [2:0] op, logic [31:0] k, logic [15:0] p, logic [7:0] o);
    set_idling();
    while ($urandom_range(0, 99) < tx_idle) begin
      req.valid <= 1'b0;
      @(negedge clk_i);
    end
    req.valid       <= 1'b1;
    req.operation   <= op;
    req.service_key <= k;
    req.port_number <= p;
    req.owner_id    <= o;
    do @(posedge clk_i); while (!req.ready);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  task automatic drain_and_idle();
    req.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(logic [15:0] base, logic [10:0] ports);
    int n;
    drain_and_idle();
    apb_write(3'(REG_PORT_BASE * 4), {16'h0, base});
    apb_write(3'(REG_PORTS_USE * 4), {21'h0, ports});
    cur_base = base;
    n = ports;
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    if (n > 65536 - int'(base)) n = 65536 - int'(base);
    cur_slots = n;
  endtask

  task automatic random_items(int count);
    logic [2:0]  op;
    logic [31:0] k;
    logic [15:0] p;
    logic [7:0]  o;
    for (int j = 0; j < count; j++) begin
      // register is drawn most often so the table fills and gets hit
      case ($urandom_range(0, 15))
        0, 1, 2, 3: op = OP_REGISTER;
        4, 5:       op = OP_UNREGISTER;
        6, 7:       op = OP_LOOKUP;
        8, 9:       op = OP_REREGISTER;
        10:         op = OP_RELEASE;
        11:         op = OP_CLEANUP;
        12, 13:     op = OP_PRELOAD;
        14:         op = 3'd7;
        default:    op = 3'($urandom_range(0, 7));
      endcase
      k = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 5)];
      if ($urandom_range(0, 4) == 0) p = 16'($urandom());
      else p = 16'(int'(cur_base) + $urandom_range(0, cur_slots));
      o = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3));
      send_item(op, k, p, o);
      if (sent_cnt == 450) drain_and_idle();
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    req.valid       = 1'b0;
    req.operation   = '0;
    req.service_key = '0;
    req.port_number = '0;
    req.owner_id    = '0;
    sent_cnt        = 0;
    tx_idle         = 0;
    rx_idle         = 0;
    cur_base        = 16'd1024;
    cur_slots       = 1024;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset setting: full table
    send_item(OP_REGISTER, 32'h0, 16'h0, 8'hFF);
    send_item(OP_LOOKUP, 32'h0, 16'h0, 8'h0);
    send_item(OP_UNREGISTER, 32'h0, 16'hFFFF, 8'h0);

    // two slots at the top of the port space
    configure(16'd65534, 11'd2);
    send_item(OP_UNREGISTER, 32'hFFFF_FFFF, 16'h0, 8'h1);  // empty table
    send_item(OP_PRELOAD, 32'hFFFF_FFFF, 16'd65535, 8'h7);
    send_item(OP_REGISTER, 32'hFFFF_FFFF, 16'h0, 8'h2);    // takes the preloaded entry
    send_item(OP_REGISTER, 32'hFFFF_FFFF, 16'h0, 8'h3);    // already registered
    send_item(OP_REGISTER, 32'h1, 16'h0, 8'h0);            // owner zero stays unowned
    send_item(OP_REGISTER, 32'h2, 16'h0, 8'h1);            // no free port
    send_item(OP_LOOKUP, 32'h1, 16'h0, 8'h0);              // unowned: unknown
    send_item(OP_REREGISTER, 32'h1, 16'd65534, 8'h4);      // recovers
    send_item(OP_REREGISTER, 32'h1, 16'd65534, 8'h4);      // owned: cannot recover
    send_item(OP_PRELOAD, 32'h5, 16'd1000, 8'h0);          // out of range
    send_item(OP_PRELOAD, 32'h5, 16'd65535, 8'h0);         // overwrite, count kept
    send_item(OP_REREGISTER, 32'h9, 16'h0, 8'h1);          // out of range
    send_item(OP_REREGISTER, 32'h9, 16'd65534, 8'h1);      // target owned
    send_item(OP_REREGISTER, 32'hA, 16'd65535, 8'h2);      // target unowned: overwrite
    send_item(OP_RELEASE, 32'h0, 16'h0, 8'h0);             // owner zero: nothing
    send_item(OP_RELEASE, 32'h0, 16'h0, 8'h4);
    send_item(OP_PRELOAD, 32'h6, 16'd65534, 8'h0);
    send_item(OP_CLEANUP, 32'h0, 16'h0, 8'h0);
    send_item(3'd7, 32'h0, 16'h0, 8'h0);                   // invalid operation
    send_item(OP_LOOKUP, 32'hA, 16'h0, 8'h0);

    configure(16'd1024, 11'd8);
    random_items(110);
    configure(16'd40000, 11'd16);
    random_items(110);
    configure(16'd65530, 11'd1024);
    random_items(110);
    configure(16'd65535, 11'd1);
    random_items(110);
    configure(16'd2000, 11'd4);
    random_items(110);
    configure(16'd1024, 11'd1024);
    random_items(12);

    drain_and_idle();
    repeat (1100) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
